@@ src/tpd_pkg.sv @@
// ----------------------------------------------------------------------------
// tpd_pkg: shared types and constants for the tablet packet decoder
// Byte-position codes, field widths and the assembled packet record.
// ----------------------------------------------------------------------------
package tpd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned LowW      = 7;
  localparam int unsigned CoordW    = 14;
  localparam int unsigned PosW      = 4;
  localparam int unsigned OutFieldW = 8 + 7 + 14 + 14 + 7;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

  // byte positions within a packet
  localparam logic [PosW-1:0] PosStatus1  = 4'd0;
  localparam logic [PosW-1:0] PosXHigh    = 4'd1;
  localparam logic [PosW-1:0] PosXLow     = 4'd2;
  localparam logic [PosW-1:0] PosStatus2  = 4'd3;
  localparam logic [PosW-1:0] PosYHigh    = 4'd4;
  localparam logic [PosW-1:0] PosYLow     = 4'd5;
  localparam logic [PosW-1:0] PosPressure = 4'd6;
  localparam logic [PosW-1:0] PosComplete = 4'd7;
  localparam logic [PosW-1:0] PosSat      = 4'd8;

  localparam logic [LowW-1:0] PressureOffset = 7'd64;

  typedef struct packed {
    logic [LowW-1:0]   pressure;
    logic [CoordW-1:0] pos_y;
    logic [CoordW-1:0] pos_x;
    logic [LowW-1:0]   status_second;
    logic [ByteW-1:0]  status_first;
  } packet_t;

endpackage

@@ src/tpd_assembler.sv @@
// ----------------------------------------------------------------------------
// tpd_assembler: packet field store and byte-position tracker
// Stores each byte at its packet position and flags a complete packet when
// a sync byte follows exactly seven bytes.
// ----------------------------------------------------------------------------
module tpd_assembler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            take_i,
  input  logic [tpd_pkg::ByteW-1:0]       rx_byte_i,
  output logic                            emit_o,
  output tpd_pkg::packet_t                packet_o
);

  logic [tpd_pkg::PosW-1:0]   pos_q, pos_d, pos_eff;
  logic [tpd_pkg::ByteW-1:0]  status1_q, status1_d;
  logic [tpd_pkg::LowW-1:0]   x_high_q, x_high_d;
  logic [tpd_pkg::CoordW-1:0] x_value_q, x_value_d;
  logic [tpd_pkg::LowW-1:0]   status2_q, status2_d;
  logic [tpd_pkg::LowW-1:0]   y_high_q, y_high_d;
  logic [tpd_pkg::CoordW-1:0] y_value_q, y_value_d;
  logic [tpd_pkg::LowW-1:0]   pressure_q, pressure_d;
  logic [tpd_pkg::LowW-1:0]   low;
  logic                       sync;

  assign sync   = rx_byte_i[tpd_pkg::ByteW-1];
  assign low    = rx_byte_i[tpd_pkg::LowW-1:0];
  assign emit_o = take_i && sync && (pos_q == tpd_pkg::PosComplete);

  assign packet_o.status_first  = status1_q;
  assign packet_o.status_second = status2_q;
  assign packet_o.pos_x         = x_value_q;
  assign packet_o.pos_y         = y_value_q;
  assign packet_o.pressure      = pressure_q;

  always_comb begin
    pos_eff    = sync ? tpd_pkg::PosStatus1 : pos_q;
    pos_d      = pos_q;
    status1_d  = status1_q;
    x_high_d   = x_high_q;
    x_value_d  = x_value_q;
    status2_d  = status2_q;
    y_high_d   = y_high_q;
    y_value_d  = y_value_q;
    pressure_d = pressure_q;
    if (take_i) begin
      unique case (pos_eff)
        tpd_pkg::PosStatus1:  status1_d  = rx_byte_i;
        tpd_pkg::PosXHigh:    x_high_d   = low;
        tpd_pkg::PosXLow:     x_value_d  = {x_high_q, low};
        tpd_pkg::PosStatus2:  status2_d  = low;
        tpd_pkg::PosYHigh:    y_high_d   = low;
        tpd_pkg::PosYLow:     y_value_d  = {y_high_q, low};
        tpd_pkg::PosPressure: pressure_d = low + tpd_pkg::PressureOffset;
        default: ;
      endcase
      pos_d = (pos_eff < tpd_pkg::PosSat) ? pos_eff + 4'd1 : pos_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= tpd_pkg::PosStatus1;
      status1_q  <= '0;
      x_high_q   <= '0;
      x_value_q  <= '0;
      status2_q  <= '0;
      y_high_q   <= '0;
      y_value_q  <= '0;
      pressure_q <= '0;
    end else begin
      pos_q      <= pos_d;
      status1_q  <= status1_d;
      x_high_q   <= x_high_d;
      x_value_q  <= x_value_d;
      status2_q  <= status2_d;
      y_high_q   <= y_high_d;
      y_value_q  <= y_value_d;
      pressure_q <= pressure_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= tpd_pkg::PosSat)
    else $error("byte position beyond saturation");

  a_sync_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && sync |=> pos_q == tpd_pkg::PosXHigh)
    else $error("sync byte did not restart the packet");

  a_pos_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && !sync && (pos_q < tpd_pkg::PosSat) |=> pos_q == $past(pos_q) + 4'd1)
    else $error("byte position did not advance");

  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take_i |=> $stable(pos_q) && $stable(x_value_q) && $stable(y_value_q))
    else $error("state changed without a byte");
`endif

endmodule

@@ src/tablet_packet_decoder.sv @@
// ----------------------------------------------------------------------------
// tablet_packet_decoder: serial pen tablet packet decoder
// Assembles seven-byte tablet packets from a byte stream into X, Y,
// pressure and status fields.
// ----------------------------------------------------------------------------
//  channel   direction  tdata fields (low bit up)
//  s_axis    in         rx_byte[7:0]
//  m_axis    out        status_first[7:0], status_second[14:8], pos_x[28:15],
//                       pos_y[42:29], pressure[49:43], zero[55:50]
//
//  One byte per cycle while m_axis is not stalled; a byte passes the input register,
//  then assembly; the result register loads a packet with the next sync byte.
//  Reset clears the byte position and all stored fields in the assembler.
//  A stalled output holds its result and the input register holds at most
//  one more byte; both stages then hold until m_axis_tready_i rises.
// ----------------------------------------------------------------------------
module tablet_packet_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [tpd_pkg::ByteW-1:0]     s_axis_tdata_i,   // rx_byte
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [tpd_pkg::OutDataW-1:0]  m_axis_tdata_o    // status_first, status_second,
                                                          // pos_x, pos_y, pressure
);

  logic                         in_valid_q, in_valid_d;
  logic [tpd_pkg::ByteW-1:0]    in_byte_q, in_byte_d;
  logic                         out_valid_q, out_valid_d;
  tpd_pkg::packet_t             out_pkt_q, out_pkt_d;
  tpd_pkg::packet_t             packet;
  logic                         advance;
  logic                         emit;
  logic                         s_xfer;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;

  tpd_assembler u_assembler (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (advance),
    .rx_byte_i (in_byte_q),
    .emit_o    (emit),
    .packet_o  (packet)
  );

  always_comb begin
    in_valid_d  = s_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    in_byte_d   = s_xfer ? s_axis_tdata_i : in_byte_q;
    out_valid_d = advance ? emit : (out_valid_q && !m_axis_tready_i);
    out_pkt_d   = (advance && emit) ? packet : out_pkt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
    out_pkt_q <= out_pkt_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(tpd_pkg::OutDataW - tpd_pkg::OutFieldW){1'b0}}, out_pkt_q};

`ifndef NO_ASSERTIONS
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q))
    else $error("input register lost a waiting byte");

  a_emit_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> advance && in_valid_q)
    else $error("packet emitted without a byte in progress");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit |=> m_axis_tvalid_o)
    else $error("emitted packet not presented");
`endif

endmodule
